FILE: src/grc_pkg.sv
// ============================================================================
// grc_pkg
// Shared types and constants for the gamepad report conditioner.
// ============================================================================
`default_nettype none

package grc_pkg;

    // Number of tracked buttons and width of the packed code word
    localparam int BTN_COUNT = 12;
    localparam int CODE_W    = 2 * BTN_COUNT;

    // Datapath word width of the serial units
    localparam int WORD_W = 64;
    localparam int DVS_W  = 33;
    localparam int CNT_W  = 7;

    // Button tracker codes
    typedef logic [1:0] btn_code_t;
    localparam btn_code_t BTN_UP   = 2'd0;
    localparam btn_code_t BTN_DOWN = 2'd1;
    localparam btn_code_t BTN_HELD = 2'd2;
    localparam btn_code_t BTN_RISE = 2'd3;

    // Mask bit that feeds each tracker; A/B and X/Y roles are swapped
    typedef logic [3:0] btn_bit_t;
    localparam btn_bit_t BTN_MAP [BTN_COUNT] = '{
        4'd13, 4'd12, 4'd14, 4'd15,
        4'd4,  4'd5,  4'd8,  4'd9,
        4'd2,  4'd3,  4'd1,  4'd0
    };

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_LEN,
        ST_DIV2,
        ST_OUT
    } seq_state_t;

    // Vector length unit phases
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_ROOT
    } sq_phase_t;

    // Status from a vector length unit
    typedef struct packed {
        logic done;
        logic over;
    } pair_stat_t;

endpackage

`default_nettype wire

FILE: src/gamepad_report_conditioner_core.sv
// ============================================================================
// gamepad_report_conditioner_core
// Stick dead zone, length clamp, button edge tracking and activity flag.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries one controller report per word.
//   Output channel (out_valid/out_stall) returns one conditioned word per
//   report. dead_zone_wr_en/dead_zone_wr_data write the dead zone register
//   (reset 13107); the user must do so only while idle (not enforced).
// Sequence:
//   Accept, then bit-serial division (four lanes at once), then serial
//   squaring and integer root (both sticks in parallel), then out_valid
//   rises. When a stick needs its length clamped, a second division runs
//   first and only that stick's axes take its quotients. A taken result
//   frees the input in the next cycle.
//   One report is in flight at a time: in_stall is high from accept until
//   the result is taken.
// Reset clears button trackers, the last packet number and the sequencer.
// A stalled result is held in place until out_stall drops.
// ============================================================================
`default_nettype none

module gamepad_report_conditioner_core
#(
    parameter int OUT_FRAC_BITS = 14
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               dead_zone_wr_en,
    input  wire logic [15:0]        dead_zone_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        pressed_mask,
    input  wire logic signed [15:0] left_x,
    input  wire logic signed [15:0] left_y,
    input  wire logic signed [15:0] right_x,
    input  wire logic signed [15:0] right_y,
    input  wire logic [7:0]         left_trigger,
    input  wire logic [7:0]         right_trigger,
    input  wire logic [31:0]        packet_number,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      move_x,
    output logic signed [15:0]      move_y,
    output logic signed [15:0]      look_x,
    output logic signed [15:0]      look_y,
    output logic [23:0]             button_codes,
    output logic                    gamepad_used
);

    localparam int F   = OUT_FRAC_BITS;
    localparam int MW  = F + 17;
    localparam int W   = grc_pkg::WORD_W;
    localparam int AXB = F + 32;
    localparam int CLB = (MW + F > W) ? W : (MW + F);
    localparam logic [15:0] DZ_RESET = 16'd13107;

    grc_pkg::seq_state_t        state_reg, state_next;
    logic                       accept;
    logic                       div_load, len_start;
    logic [3:0]                 div_done;
    logic [W-1:0]               div_q [4];
    logic [W-1:0]               div_dvd [4];
    logic [grc_pkg::DVS_W-1:0]  div_dvs [4];
    logic [grc_pkg::CNT_W-1:0]  div_n;
    logic [grc_pkg::DVS_W-1:0]  len_root [2];
    grc_pkg::pair_stat_t        len_stat [2];
    logic                       any_over;

    logic [15:0]                dead_zone_reg;
    logic [31:0]                last_packet_reg;
    grc_pkg::btn_code_t         tracker_reg [grc_pkg::BTN_COUNT];
    grc_pkg::btn_code_t         tracker_next [grc_pkg::BTN_COUNT];
    logic [grc_pkg::CODE_W-1:0] codes_reg;
    logic                       used_reg;
    logic [MW-1:0]              m_reg [4];
    logic [3:0]                 neg_reg;
    logic [1:0]                 over_reg;

    logic [15:0]                raw [4];
    logic [16:0]                mag [4];
    logic [32:0]                prod [4];
    logic [31:0]                num [4];
    logic [3:0]                 act;
    logic [16:0]                dz_span;
    logic [31:0]                dz_sub, den;
    logic                       used_now;

    assign accept = in_valid && !in_stall;

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            grc_pkg::ST_IDLE: if (accept) state_next = grc_pkg::ST_DIV1;
            grc_pkg::ST_DIV1: if (div_done[0]) state_next = grc_pkg::ST_LEN;
            grc_pkg::ST_LEN:
                if (len_stat[0].done)
                    state_next = any_over ? grc_pkg::ST_DIV2 : grc_pkg::ST_OUT;
            grc_pkg::ST_DIV2: if (div_done[0]) state_next = grc_pkg::ST_OUT;
            grc_pkg::ST_OUT:  if (!out_stall) state_next = grc_pkg::ST_IDLE;
            default:          state_next = grc_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        div_load  = 1'b0;
        len_start = 1'b0;
        unique case (state_reg)
            grc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                div_load = in_valid;
            end
            grc_pkg::ST_DIV1: len_start = div_done[0];
            grc_pkg::ST_LEN:  div_load  = len_stat[0].done && any_over;
            grc_pkg::ST_OUT:  out_valid = 1'b1;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= grc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // both length units run in lockstep
    assign any_over = len_stat[0].over || len_stat[1].over;

    // dead zone constants: d*32767 and 32767*(65536-d)
    always_comb
    begin
        dz_span = 17'h10000 - {1'b0, dead_zone_reg};
        dz_sub  = {1'b0, dead_zone_reg, 15'd0} - 32'(dead_zone_reg);
        den     = {dz_span[16:0], 15'd0} - 32'(dz_span);
    end

    // per-axis magnitude and dead zone removal
    assign raw[0] = left_x;
    assign raw[1] = left_y;
    assign raw[2] = right_x;
    assign raw[3] = right_y;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i]  = raw[i][15] ? (17'h10000 - {1'b0, raw[i]}) : {1'b0, raw[i]};
            prod[i] = {mag[i], 16'd0};
            num[i]  = (prod[i] > {1'b0, dz_sub}) ? 32'(prod[i] - {1'b0, dz_sub}) : '0;
            act[i]  = (num[i] != '0);
        end
    end

    // divider operands: axis scaling, or length clamp
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (state_reg == grc_pkg::ST_IDLE)
            begin
                div_dvd[i] = ((W'(num[i]) << F) + W'(den >> 1)) << (W - AXB);
                div_dvs[i] = grc_pkg::DVS_W'(den);
            end
            else
            begin
                div_dvd[i] = (W'(m_reg[i]) << F) << (W - CLB);
                div_dvs[i] = len_root[i / 2];
            end
        end
        div_n = (state_reg == grc_pkg::ST_IDLE) ? grc_pkg::CNT_W'(AXB)
                                                 : grc_pkg::CNT_W'(CLB);
    end

    // four divider lanes
    for (genvar g = 0; g < 4; g++)
    begin : g_div
        grc_div u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (div_load),
            .n_bits   (div_n),
            .dividend (div_dvd[g]),
            .divisor  (div_dvs[g]),
            .quotient (div_q[g]),
            .done     (div_done[g])
        );
    end

    // one length unit per stick
    for (genvar p = 0; p < 2; p++)
    begin : g_len
        grc_len #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_len
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (len_start),
            .x     (div_q[2*p][MW-1:0]),
            .y     (div_q[2*p+1][MW-1:0]),
            .root  (len_root[p]),
            .stat  (len_stat[p])
        );
    end

    // button trackers
    always_comb
    begin
        for (int i = 0; i < grc_pkg::BTN_COUNT; i++)
        begin
            if (tracker_reg[i] == grc_pkg::BTN_UP || tracker_reg[i] == grc_pkg::BTN_RISE)
                tracker_next[i] = pressed_mask[grc_pkg::BTN_MAP[i]] ? grc_pkg::BTN_DOWN
                                                                     : grc_pkg::BTN_UP;
            else
                tracker_next[i] = pressed_mask[grc_pkg::BTN_MAP[i]] ? grc_pkg::BTN_HELD
                                                                     : grc_pkg::BTN_RISE;
        end
    end

    assign used_now = (pressed_mask != '0) || (left_trigger != '0) || (right_trigger != '0)
                      || (act != '0) || (packet_number != last_packet_reg);

    // register, trackers and packet history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg   <= DZ_RESET;
            last_packet_reg <= '0;
            for (int i = 0; i < grc_pkg::BTN_COUNT; i++)
                tracker_reg[i] <= grc_pkg::BTN_UP;
        end
        else
        begin
            if (dead_zone_wr_en)
                dead_zone_reg <= dead_zone_wr_data;
            if (accept)
            begin
                last_packet_reg <= packet_number;
                for (int i = 0; i < grc_pkg::BTN_COUNT; i++)
                    tracker_reg[i] <= tracker_next[i];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            used_reg <= used_now;
            for (int i = 0; i < 4; i++)
                neg_reg[i] <= raw[i][15];
            for (int i = 0; i < grc_pkg::BTN_COUNT; i++)
                codes_reg[2*i +: 2] <= tracker_next[i];
        end
        if (state_reg == grc_pkg::ST_DIV1 && div_done[0])
        begin
            for (int i = 0; i < 4; i++)
                m_reg[i] <= div_q[i][MW-1:0];
        end
        if (state_reg == grc_pkg::ST_LEN && len_stat[0].done)
        begin
            over_reg[0] <= len_stat[0].over;
            over_reg[1] <= len_stat[1].over;
        end
        if (state_reg == grc_pkg::ST_DIV2 && div_done[0])
        begin
            for (int i = 0; i < 4; i++)
                if (over_reg[i / 2])
                    m_reg[i] <= div_q[i][MW-1:0];
        end
    end

    // sign restore, low 16 bits
    assign move_x = neg_reg[0] ? (16'd0 - m_reg[0][15:0]) : m_reg[0][15:0];
    assign move_y = neg_reg[1] ? (16'd0 - m_reg[1][15:0]) : m_reg[1][15:0];
    assign look_x = neg_reg[2] ? (16'd0 - m_reg[2][15:0]) : m_reg[2][15:0];
    assign look_y = neg_reg[3] ? (16'd0 - m_reg[3][15:0]) : m_reg[3][15:0];
    assign button_codes = codes_reg;
    assign gamepad_used = used_reg;

    // checks
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == grc_pkg::ST_DIV1) && !out_valid)
        else $error("accepted word did not start division");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid && !in_stall)
        else $error("result taken but block not idle");

    a_div_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> (state_reg == grc_pkg::ST_DIV1 || state_reg == grc_pkg::ST_DIV2))
        else $error("divider finished outside a divide phase");

    a_len_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        len_stat[0].done == len_stat[1].done)
        else $error("length units out of step");

    a_len_phase: assert property (@(posedge clk) disable iff (!rst_n)
        len_stat[0].done |-> state_reg == grc_pkg::ST_LEN)
        else $error("length unit finished outside its phase");

endmodule

`default_nettype wire

FILE: src/grc_div.sv
// ============================================================================
// grc_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ============================================================================
`default_nettype none

module grc_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [grc_pkg::CNT_W-1:0]   n_bits,
    input  wire logic [grc_pkg::WORD_W-1:0]  dividend,
    input  wire logic [grc_pkg::DVS_W-1:0]   divisor,
    output logic      [grc_pkg::WORD_W-1:0]  quotient,
    output logic                             done
);

    localparam int RW = grc_pkg::DVS_W + 1;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [grc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [grc_pkg::WORD_W-1:0]  dvd_reg, dvd_next;
    logic [grc_pkg::WORD_W-1:0]  q_reg, q_next;
    logic [RW-1:0]               rem_reg, rem_next;
    logic [grc_pkg::DVS_W-1:0]   dvs_reg, dvs_next;
    logic [RW-1:0]               trial;
    logic                        fits;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg[RW-2:0], dvd_reg[grc_pkg::WORD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = n_bits;
            dvd_next  = dividend;
            q_next    = '0;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[grc_pkg::WORD_W-2:0], 1'b0};
            q_next   = {q_reg[grc_pkg::WORD_W-2:0], fits};
            rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == grc_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: src/grc_len.sv
// ============================================================================
// grc_len
// Stick vector length: serial sum of squares, then bit-pair integer root.
// ============================================================================
`default_nettype none

module grc_len
#(
    parameter int OUT_FRAC_BITS = 14
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [OUT_FRAC_BITS+16:0]     x,
    input  wire logic [OUT_FRAC_BITS+16:0]     y,
    output logic      [grc_pkg::DVS_W-1:0]     root,
    output grc_pkg::pair_stat_t                stat
);

    localparam int MW = OUT_FRAC_BITS + 17;
    localparam int W  = grc_pkg::WORD_W;
    localparam logic [W-1:0] ONE_SQ    = W'(1) << (2 * OUT_FRAC_BITS);
    localparam logic [W-1:0] ROOT_BIT0 = W'(1) << (W - 2);
    localparam int ROOT_STEPS = W / 2;

    grc_pkg::sq_phase_t          phase_reg, phase_next;
    logic [grc_pkg::CNT_W-1:0]   cnt_reg;
    logic                        done_reg, over_reg;
    logic [W-1:0]                xs_reg, ys_reg, acc_reg, res_reg, bit_reg;
    logic [MW-1:0]               xb_reg, yb_reg;
    logic [W-1:0]                trial;
    logic                        last_step, mul_on, root_on;

    assign last_step = (cnt_reg == grc_pkg::CNT_W'(1));
    assign trial     = res_reg + bit_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            grc_pkg::SQ_IDLE: if (start) phase_next = grc_pkg::SQ_MUL;
            grc_pkg::SQ_MUL:  if (last_step) phase_next = grc_pkg::SQ_ROOT;
            grc_pkg::SQ_ROOT: if (last_step) phase_next = grc_pkg::SQ_IDLE;
            default:          phase_next = grc_pkg::SQ_IDLE;
        endcase
    end

    // phase decodes
    always_comb
    begin
        mul_on  = 1'b0;
        root_on = 1'b0;
        unique case (phase_reg)
            grc_pkg::SQ_MUL:  mul_on  = 1'b1;
            grc_pkg::SQ_ROOT: root_on = 1'b1;
            default:          ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= grc_pkg::SQ_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= root_on && last_step;
            if (phase_reg == grc_pkg::SQ_IDLE && start)
                cnt_reg <= grc_pkg::CNT_W'(MW);
            else if (mul_on && last_step)
                cnt_reg <= grc_pkg::CNT_W'(ROOT_STEPS);
            else if (mul_on || root_on)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // square-sum and root datapath, wraps at 64 bits
    always_ff @(posedge clk)
    begin
        if (phase_reg == grc_pkg::SQ_IDLE && start)
        begin
            xs_reg  <= W'(x);
            ys_reg  <= W'(y);
            xb_reg  <= x;
            yb_reg  <= y;
            acc_reg <= '0;
        end
        else if (mul_on)
        begin
            acc_reg <= acc_reg + (xb_reg[0] ? xs_reg : '0) + (yb_reg[0] ? ys_reg : '0);
            xs_reg  <= {xs_reg[W-2:0], 1'b0};
            ys_reg  <= {ys_reg[W-2:0], 1'b0};
            xb_reg  <= xb_reg >> 1;
            yb_reg  <= yb_reg >> 1;
            res_reg <= '0;
            bit_reg <= ROOT_BIT0;
        end
        else if (root_on)
        begin
            // first root cycle still sees the full sum
            if (cnt_reg == grc_pkg::CNT_W'(ROOT_STEPS))
                over_reg <= (acc_reg > ONE_SQ);
            if (acc_reg >= trial)
            begin
                acc_reg <= acc_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root      = res_reg[grc_pkg::DVS_W-1:0];
    assign stat.done = done_reg;
    assign stat.over = over_reg;

endmodule

`default_nettype wire
